// ----- sv/lfs_pkg.sv -----
package lfs_pkg;

  localparam int unsigned INTERVAL_W = 20;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd50000;

  localparam logic [4:0] PAT_STOP   = 5'b11011;
  localparam logic [4:0] PAT_CENTRE = 5'b00100;

  typedef enum logic [1:0] {
    MODE_CENTRE = 2'd0,
    MODE_LEFT   = 2'd1,
    MODE_RIGHT  = 2'd2,
    MODE_STOP   = 2'd3
  } steer_mode_t;

  typedef logic signed [5:0] drive_t;
  typedef logic signed [6:0] drive_sum_t;

  typedef struct packed {
    steer_mode_t mode;
    logic        wait_active;
    logic        wait_spins;
  } steer_state_t;

  typedef struct packed {
    drive_t left_drive;
    drive_t right_drive;
    logic   waiting;
  } steer_result_t;

  localparam drive_sum_t W_EDGE_NEG  = -7'sd4;
  localparam drive_sum_t W_EDGE_POS  = 7'sd8;
  localparam drive_sum_t W_BIG       = 7'sd12;
  localparam drive_sum_t W_SMALL     = 7'sd6;
  localparam drive_sum_t DRIVE_MAX   = 7'sd16;

  localparam drive_t DRIVE_ZERO      = 6'sd0;
  localparam drive_t DRIVE_PIVOT_NEG = -6'sd8;
  localparam drive_t DRIVE_PIVOT_POS = 6'sd16;
  localparam drive_t DRIVE_SPIN_POS  = 6'sd8;
  localparam drive_t DRIVE_SPIN_NEG  = -6'sd8;

endpackage

// ----- sv/line_follower_steering.sv -----
// pipeline: an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle; in_stall rises only while the result register
//   is held by out_stall and the input register is full
// reset (rst_n low, synchronous): stop mode, not waiting, interval 50000,
//   idle count equal to the interval, both registers empty
module line_follower_steering import lfs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [INTERVAL_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [4:0]            in_sensor_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [5:0]     out_left_drive,
  output logic signed [5:0]     out_right_drive,
  output logic                  out_waiting
);

  logic [INTERVAL_W-1:0]  interval_r;
  steer_state_t           st_r;
  steer_state_t           st_nxt;
  logic [COUNT_WIDTH-1:0] idle_count_r;
  logic [COUNT_WIDTH-1:0] idle_count_nxt;
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [4:0]             s1_bits_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  steer_result_t          out_res_r;
  steer_result_t          res;
  logic                   out_free;
  logic                   in_accept;
  logic                   fire;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign fire      = s1_valid_r && out_free;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !out_free);
  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  lfs_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .sensor_bits    (s1_bits_r),
    .st             (st_r),
    .idle_count     (idle_count_r),
    .change_interval(interval_r),
    .st_nxt         (st_nxt),
    .idle_count_nxt (idle_count_nxt),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= INTERVAL_RESET;
      st_r         <= '{mode: MODE_STOP, wait_active: 1'b0, wait_spins: 1'b0};
      idle_count_r <= COUNT_WIDTH'(INTERVAL_RESET);
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
      if (fire) begin
        st_r         <= st_nxt;
        idle_count_r <= idle_count_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_bits_r <= in_sensor_bits;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = out_res_r.left_drive;
  assign out_right_drive = out_res_r.right_drive;
  assign out_waiting     = out_res_r.waiting;

endmodule

// ----- sv/lfs_step.sv -----
module lfs_step import lfs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic [4:0]             sensor_bits,
  input  steer_state_t           st,
  input  logic [COUNT_WIDTH-1:0] idle_count,
  input  logic [INTERVAL_W-1:0]  change_interval,
  output steer_state_t           st_nxt,
  output logic [COUNT_WIDTH-1:0] idle_count_nxt,
  output steer_result_t          res
);

  localparam int unsigned CMP_W =
    ((COUNT_WIDTH > INTERVAL_W) ? COUNT_WIDTH : INTERVAL_W) + 1;

  logic [CMP_W-1:0]       interval_ext;
  logic [CMP_W-1:0]       mask_ext;
  logic [CMP_W-1:0]       lim;
  logic [CMP_W-1:0]       cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_src;
  logic                   cnt_upd;
  logic [COUNT_WIDTH-1:0] c_line;
  logic [COUNT_WIDTH-1:0] c_after;
  steer_mode_t            mode_eff;
  steer_mode_t            mode_line;
  logic                   line_seen;
  logic                   due;
  logic                   swap;
  logic                   is_centre;
  drive_sum_t             l_sum;
  drive_sum_t             r_sum;
  drive_t                 l_sat;
  drive_t                 r_sat;

  assign interval_ext = CMP_W'(change_interval);
  assign mask_ext     = CMP_W'({COUNT_WIDTH{1'b1}});
  assign lim          = (interval_ext < mask_ext) ? interval_ext : mask_ext;

  assign is_centre = (sensor_bits == PAT_CENTRE);
  assign mode_eff  = (sensor_bits == PAT_STOP) ? MODE_STOP : st.mode;
  assign line_seen = (sensor_bits != 5'd0) && (mode_eff != MODE_STOP);
  assign due       = CMP_W'(idle_count) >= interval_ext;

  // bit 0 clears the count before the inner weights look at it
  assign c_line  = sensor_bits[0] ? '0 : idle_count;
  assign c_after = (sensor_bits[0] || sensor_bits[4]) ? '0 : idle_count;
  assign swap    = CMP_W'(c_line) >= interval_ext;

  always_comb begin
    l_sum = '0;
    r_sum = '0;
    if (sensor_bits[0]) begin
      l_sum = l_sum + W_EDGE_NEG;
      r_sum = r_sum + W_EDGE_POS;
    end
    if (sensor_bits[1]) begin
      l_sum = l_sum + (swap ? W_SMALL : W_BIG);
      r_sum = r_sum + (swap ? W_BIG : W_SMALL);
    end
    if (sensor_bits[2]) begin
      l_sum = l_sum + W_BIG;
      r_sum = r_sum + W_BIG;
    end
    if (sensor_bits[3]) begin
      l_sum = l_sum + (swap ? W_BIG : W_SMALL);
      r_sum = r_sum + (swap ? W_SMALL : W_BIG);
    end
    if (sensor_bits[4]) begin
      l_sum = l_sum + W_EDGE_POS;
      r_sum = r_sum + W_EDGE_NEG;
    end
  end

  assign l_sat = (l_sum > DRIVE_MAX) ? drive_t'(DRIVE_MAX) : l_sum[5:0];
  assign r_sat = (r_sum > DRIVE_MAX) ? drive_t'(DRIVE_MAX) : r_sum[5:0];

  // highest lit sensor sets the mode
  always_comb begin
    if (sensor_bits[4] || sensor_bits[3]) begin
      mode_line = MODE_RIGHT;
    end else if (sensor_bits[2]) begin
      mode_line = MODE_CENTRE;
    end else begin
      mode_line = MODE_LEFT;
    end
  end

  // next state
  always_comb begin
    st_nxt  = st;
    cnt_src = idle_count;
    cnt_upd = 1'b0;
    if (st.wait_active) begin
      if (is_centre) begin
        st_nxt.wait_active = 1'b0;
        cnt_src            = '0;
        cnt_upd            = 1'b1;
      end
    end else if (line_seen) begin
      st_nxt.mode = mode_line;
      cnt_src     = c_after;
      cnt_upd     = 1'b1;
    end else begin
      st_nxt.mode = mode_eff;
      if (mode_eff == MODE_CENTRE && due) begin
        st_nxt.wait_active = 1'b1;
        st_nxt.wait_spins  = 1'b1;
      end else if (mode_eff == MODE_STOP && due) begin
        if (is_centre) begin
          cnt_src = '0;
          cnt_upd = 1'b1;
        end else begin
          st_nxt.wait_active = 1'b1;
          st_nxt.wait_spins  = 1'b0;
        end
      end else begin
        cnt_upd = 1'b1;
      end
    end
  end

  assign cnt_inc = CMP_W'(cnt_src) + CMP_W'(1);

  always_comb begin
    if (!cnt_upd) begin
      idle_count_nxt = idle_count;
    end else if (cnt_inc > lim) begin
      idle_count_nxt = lim[COUNT_WIDTH-1:0];
    end else begin
      idle_count_nxt = cnt_inc[COUNT_WIDTH-1:0];
    end
  end

  // result
  always_comb begin
    res = '{left_drive: DRIVE_ZERO, right_drive: DRIVE_ZERO, waiting: 1'b0};
    if (st.wait_active) begin
      if (!is_centre) begin
        res.waiting = 1'b1;
        if (st.wait_spins) begin
          res.left_drive  = DRIVE_SPIN_POS;
          res.right_drive = DRIVE_SPIN_NEG;
        end
      end
    end else if (line_seen) begin
      res.left_drive  = l_sat;
      res.right_drive = r_sat;
    end else if (mode_eff == MODE_CENTRE && due) begin
      res.left_drive  = DRIVE_SPIN_POS;
      res.right_drive = DRIVE_SPIN_NEG;
      res.waiting     = 1'b1;
    end else if (mode_eff == MODE_STOP && due) begin
      res.waiting = !is_centre;
    end else begin
      unique case (mode_eff)
        MODE_LEFT: begin
          res.left_drive  = DRIVE_PIVOT_NEG;
          res.right_drive = DRIVE_PIVOT_POS;
        end
        MODE_RIGHT: begin
          res.left_drive  = DRIVE_PIVOT_POS;
          res.right_drive = DRIVE_PIVOT_NEG;
        end
        default: begin
          res.left_drive  = DRIVE_ZERO;
          res.right_drive = DRIVE_ZERO;
        end
      endcase
    end
  end

endmodule
